[rtl/core/clock_replacement_block_cache_tags_defines.svh]
// ----------------------------------------------------------------------------
// Block cache tag manager assertion macros
// Shared assertion forms for the checker, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_REPLACEMENT_BLOCK_CACHE_TAGS_DEFINES_SVH
`define CLOCK_REPLACEMENT_BLOCK_CACHE_TAGS_DEFINES_SVH

// same-cycle implication
`define CBCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbct check failed");

// next-cycle implication
`define CBCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbct check failed");

`endif

[rtl/core/cbct_pkg.sv]
// ----------------------------------------------------------------------------
// Block cache tag manager package
// Transaction payload types, cell control and read-out types, cell op codes.
// ----------------------------------------------------------------------------
package cbct_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  // operation applied to the cell holding the token
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_SETREF = 3'd2;
  localparam logic [2:0] OP_CLRREF = 3'd3;
  localparam logic [2:0] OP_INVAL  = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] file_id;
    logic [31:0] block_number;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  entry_index;
    logic        writeback;
    logic [31:0] wb_file_id;
    logic [31:0] wb_block;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        restart;
    logic        shift;
    logic [2:0]  op;
  } cell_ctl_t;

  typedef struct packed {
    logic [31:0] file_tag;
    logic [31:0] block_tag;
  } key_t;

  typedef struct packed {
    logic        valid;
    logic        refd;
    logic        match_file;
    logic        match_blk;
    logic [31:0] file_tag;
    logic [31:0] block_tag;
  } cell_rd_t;

endpackage

[rtl/core/cbct_cell.sv]
// ----------------------------------------------------------------------------
// Block cache tag cell
// One cache entry plus one stage of the token ring. The cell holding the
// token drives its state on the read-out bus and takes the current op.
// ----------------------------------------------------------------------------
module cbct_cell #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbct_pkg::cell_ctl_t ctl,
  input  cbct_pkg::key_t      key,
  input  logic                tok_in,
  output logic                tok_out,
  output cbct_pkg::cell_rd_t  rd
);

  logic        tok_r,   tok_nxt;
  logic        valid_r, valid_nxt;
  logic        ref_r,   ref_nxt;
  logic [31:0] file_r;
  logic [31:0] block_r;

  always_comb begin
    tok_nxt = tok_r;
    if (ctl.restart) begin
      tok_nxt = IS_FIRST;
    end else if (ctl.shift) begin
      tok_nxt = tok_in;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    if (tok_r) begin
      case (ctl.op)
        cbct_pkg::OP_FILL: begin
          valid_nxt = 1'b1;
          ref_nxt   = 1'b1;
        end
        cbct_pkg::OP_SETREF: ref_nxt   = 1'b1;
        cbct_pkg::OP_CLRREF: ref_nxt   = 1'b0;
        cbct_pkg::OP_INVAL:  valid_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_r && ctl.op == cbct_pkg::OP_FILL) begin
      file_r  <= key.file_tag;
      block_r <= key.block_tag;
    end
  end

  assign tok_out = tok_r;

  always_comb begin
    rd = '0;
    if (tok_r) begin
      rd.valid      = valid_r;
      rd.refd       = ref_r;
      rd.match_file = (file_r == key.file_tag);
      rd.match_blk  = (block_r == key.block_tag);
      rd.file_tag   = file_r;
      rd.block_tag  = block_r;
    end
  end

endmodule

[rtl/core/clock_replacement_block_cache_tags.sv]
// ----------------------------------------------------------------------------
// Block cache tag manager with clock replacement
// Fully associative tag store as a ring of entry cells; a token visits one
// cell per cycle for lookup, allocation, second-chance sweep and close flush.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  input   | in_valid  / in_ready  / in_data  | cbct_pkg::in_t
//  result  | out_valid / out_ready / out_data | cbct_pkg::out_t
//
// One transaction at a time; the token steps one cell per cycle. A miss fills
// the first free entry; a full miss takes at most a lookup pass, one clearing
// sweep pass, then entry 0. Close visits every entry; an unused mode gives
// only a final result. Reset clears all valid and referenced bits at once.
// A stalled result register holds the token at a due result until it drains.
// ----------------------------------------------------------------------------
module clock_replacement_block_cache_tags #(
  parameter int ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbct_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cbct_pkg::out_t out_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $bits(cbct_pkg::cell_rd_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_VICT  = 3'd2;
  localparam logic [2:0] ST_CLOSE = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                free_r, free_nxt;
  logic                wr_r;
  cbct_pkg::key_t      key_r;
  logic                out_valid_r;
  cbct_pkg::out_t      out_data_r;

  cbct_pkg::cell_ctl_t ctl;
  cbct_pkg::cell_rd_t  rd [ENTRIES];
  cbct_pkg::cell_rd_t  cur;
  logic [ENTRIES-1:0]  tok;
  logic [RW-1:0]       rd_or;

  logic                accept;
  logic                can_emit;
  logic                emit;
  cbct_pkg::out_t      emit_data;
  logic                idx_last;
  logic [IW+3:0]       idx_ext;
  logic [3:0]          idx4;

  // entry cell ring
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cbct_cell #(.IS_FIRST(g == 0)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .key     (key_r),
      .tok_in  (tok[(g + ENTRIES - 1) % ENTRIES]),
      .tok_out (tok[g]),
      .rd      (rd[g])
    );
  end

  // token is one-hot, so an OR gives the visited cell
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_or = rd_or | rd[i];
    end
  end
  assign cur = cbct_pkg::cell_rd_t'(rd_or);

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign can_emit = !out_valid_r || out_ready;
  assign idx_last = (idx_r == IW'(ENTRIES - 1));
  assign idx_ext  = {4'b0, idx_r};
  assign idx4     = idx_ext[3:0];

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    free_nxt    = free_r;
    ctl.restart = 1'b0;
    ctl.shift   = 1'b0;
    ctl.op      = cbct_pkg::OP_NOP;
    emit        = 1'b0;
    emit_data   = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.restart = 1'b1;
          idx_nxt     = '0;
          free_nxt    = 1'b0;
          case (in_data.mode)
            cbct_pkg::MODE_READ:  state_nxt = ST_LOOK;
            cbct_pkg::MODE_WRITE: state_nxt = ST_LOOK;
            cbct_pkg::MODE_CLOSE: state_nxt = ST_CLOSE;
            default:              state_nxt = ST_FIN;
          endcase
        end
      end

      ST_LOOK: begin
        if (cur.valid && cur.match_file && cur.match_blk) begin
          if (can_emit) begin
            emit                  = 1'b1;
            emit_data.hit         = 1'b1;
            emit_data.entry_index = idx4;
            emit_data.last        = 1'b1;
            ctl.op    = wr_r ? cbct_pkg::OP_SETREF : cbct_pkg::OP_NOP;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (!cur.valid) begin
            free_nxt = 1'b1;
          end
          // ring wraps, so the sweep starts again at entry 0
          ctl.shift = 1'b1;
          idx_nxt   = idx_last ? '0 : idx_r + 1'b1;
          if (idx_last) begin
            state_nxt = ST_VICT;
          end
        end
      end

      ST_VICT: begin
        if (free_r ? !cur.valid : !cur.refd) begin
          if (can_emit) begin
            emit                  = 1'b1;
            emit_data.entry_index = idx4;
            emit_data.writeback   = !free_r;
            emit_data.wb_file_id  = free_r ? 32'd0 : cur.file_tag;
            emit_data.wb_block    = free_r ? 32'd0 : cur.block_tag;
            emit_data.last        = 1'b1;
            ctl.op    = cbct_pkg::OP_FILL;
            state_nxt = ST_IDLE;
          end
        end else begin
          // full cache: second chance for referenced entries; else skip taken entries
          ctl.op    = free_r ? cbct_pkg::OP_NOP : cbct_pkg::OP_CLRREF;
          ctl.shift = 1'b1;
          idx_nxt   = idx_last ? '0 : idx_r + 1'b1;
        end
      end

      ST_CLOSE: begin
        if (cur.valid && cur.match_file) begin
          if (can_emit) begin
            emit                  = 1'b1;
            emit_data.entry_index = idx4;
            emit_data.writeback   = 1'b1;
            emit_data.wb_file_id  = cur.file_tag;
            emit_data.wb_block    = cur.block_tag;
            ctl.op    = cbct_pkg::OP_INVAL;
            ctl.shift = 1'b1;
            idx_nxt   = idx_last ? '0 : idx_r + 1'b1;
            if (idx_last) begin
              state_nxt = ST_FIN;
            end
          end
        end else begin
          ctl.shift = 1'b1;
          idx_nxt   = idx_last ? '0 : idx_r + 1'b1;
          if (idx_last) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (can_emit) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      free_r  <= free_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r.file_tag  <= in_data.file_id;
      key_r.block_tag <= in_data.block_number;
      wr_r            <= (in_data.mode == cbct_pkg::MODE_WRITE);
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/cbct_checker.sv]
// ----------------------------------------------------------------------------
// Block cache tag manager checker
// Port-level checks on the result channel and input flow, bound to the top.
// ----------------------------------------------------------------------------
`include "clock_replacement_block_cache_tags_defines.svh"

module cbct_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cbct_pkg::out_t out_data
);

  `CBCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CBCT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  // a hit never carries a write-back and always ends its transaction
  `CBCT_ASSERT_NOW(a_hit_final, out_valid && out_data.hit,
                   !out_data.writeback && out_data.last)
  // only close flushes give non-final results
  `CBCT_ASSERT_NOW(a_flush_shape, out_valid && !out_data.last,
                   out_data.writeback && !out_data.hit)
  `CBCT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind clock_replacement_block_cache_tags cbct_checker u_cbct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/clock_replacement_checker.sv]
// ----------------------------------------------------------------------------
// Block cache tag manager checker
// Watches both channels. Keeps its own copy of the tag store, the valid and
// referenced bits and the clock sweep, predicts the results of every accepted
// transaction and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module clock_replacement_checker
  import cbct_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   n_in,
  output int   n_out,
  output int   n_hit,
  output int   n_evict,
  output int   n_flush
);

  logic        slot_valid [ENTRIES];
  logic        slot_ref   [ENTRIES];
  logic [31:0] slot_file  [ENTRIES];
  logic [31:0] slot_block [ENTRIES];

  out_t expected_results [$];
  out_t want;

  function automatic out_t make_result(logic hit, int idx, logic wb, logic [31:0] wfile,
                                       logic [31:0] wblock, logic last);
    out_t r;
    r.hit         = hit;
    r.entry_index = 4'(idx);
    r.writeback   = wb;
    r.wb_file_id  = wfile;
    r.wb_block    = wblock;
    r.last        = last;
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // updates the tag store for one transaction and queues what it returns
  task automatic predict_access(in_t t);
    int slot;
    slot = -1;
    case (t.mode)
      MODE_CLOSE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && slot_file[i] == t.file_id) begin
            expected_results.push_back(make_result(1'b0, i, 1'b1, slot_file[i],
                                                   slot_block[i], 1'b0));
            slot_valid[i] = 1'b0;
            n_flush++;
          end
        end
        expected_results.push_back(make_result(1'b0, 0, 1'b0, '0, '0, 1'b1));
      end
      MODE_READ, MODE_WRITE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && slot_valid[i] && slot_file[i] == t.file_id &&
              slot_block[i] == t.block_number) slot = i;
        if (slot >= 0) begin
          if (t.mode == MODE_WRITE) slot_ref[slot] = 1'b1;
          expected_results.push_back(make_result(1'b1, slot, 1'b0, '0, '0, 1'b1));
          n_hit++;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !slot_valid[i]) slot = i;
          if (slot < 0) begin
            // second chance: two passes from entry 0 at most
            for (int pass = 0; pass < 2 && slot < 0; pass++)
              for (int i = 0; i < ENTRIES && slot < 0; i++) begin
                if (!slot_ref[i]) slot = i;
                else slot_ref[i] = 1'b0;
              end
            if (slot < 0) slot = 0;
            expected_results.push_back(make_result(1'b0, slot, 1'b1, slot_file[slot],
                                                   slot_block[slot], 1'b1));
            n_evict++;
          end else begin
            expected_results.push_back(make_result(1'b0, slot, 1'b0, '0, '0, 1'b1));
          end
          slot_valid[slot] = 1'b1;
          slot_ref[slot]   = 1'b1;
          slot_file[slot]  = t.file_id;
          slot_block[slot] = t.block_number;
        end
      end
      default: expected_results.push_back(make_result(1'b0, 0, 1'b0, '0, '0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_ref[i]   = 1'b0;
      end
      fail_count = 0;
      n_in       = 0;
      n_out      = 0;
      n_hit      = 0;
      n_evict    = 0;
      n_flush    = 0;
    end else begin
      // a result never leaves in the cycle its transaction enters
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf({"unexpected result: hit=%0d idx=%0d wb=%0d ",
                                  "file=%h blk=%h last=%0d"},
                                 out_data.hit, out_data.entry_index, out_data.writeback,
                                 out_data.wb_file_id, out_data.wb_block, out_data.last));
        end else begin
          want = expected_results.pop_front();
          if (out_data.hit !== want.hit || out_data.entry_index !== want.entry_index ||
              out_data.writeback !== want.writeback ||
              out_data.wb_file_id !== want.wb_file_id ||
              out_data.wb_block !== want.wb_block || out_data.last !== want.last) begin
            note_failure($sformatf({"result mismatch: exp hit=%0d idx=%0d wb=%0d file=%h ",
                                    "blk=%h last=%0d, got hit=%0d idx=%0d wb=%0d file=%h ",
                                    "blk=%h last=%0d"},
                                   want.hit, want.entry_index, want.writeback,
                                   want.wb_file_id, want.wb_block, want.last,
                                   out_data.hit, out_data.entry_index, out_data.writeback,
                                   out_data.wb_file_id, out_data.wb_block, out_data.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        predict_access(in_data);
      end
    end
    pending <= expected_results.size();
  end

endmodule

[tb/tb_clock_replacement_block_cache_tags.sv]
// ----------------------------------------------------------------------------
// Block cache tag manager testbench
// Directed accesses fill, hit, evict and flush the tag store, then random
// reads, writes, closes and unused modes, mostly on a small set of files and
// blocks, keep the cache full and cycling with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_clock_replacement_block_cache_tags;
  import cbct_pkg::*;

  localparam int         NUM_ENTRIES  = 16;
  localparam int         RANDOM_ITEMS = 300;
  localparam int         DRAIN_CYCLES = 100;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count, pending, n_in, n_out, n_hit, n_evict, n_flush;
  int in_quiet;

  logic [31:0] file_pool  [4];
  logic [31:0] block_pool [12];

  clock_replacement_block_cache_tags #(
    .ENTRIES (NUM_ENTRIES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  clock_replacement_checker #(
    .ENTRIES (NUM_ENTRIES)
  ) tag_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_in       (n_in),
    .n_out      (n_out),
    .n_hit      (n_hit),
    .n_evict    (n_evict),
    .n_flush    (n_flush)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // gap before the next transaction; now and then a run with no gaps at all
  function automatic int draw_wait(inout int quiet_run);
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_run = $urandom_range(8, 30);
    return $urandom_range(0, 6);
  endfunction

  function automatic in_t make_item(logic [1:0] mode, logic [31:0] file_id,
                                    logic [31:0] block_number);
    in_t t;
    t.mode         = mode;
    t.file_id      = file_id;
    t.block_number = block_number;
    return t;
  endfunction

  task automatic send(in_t t);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // result side back-pressure
  initial begin
    int stall;
    int out_quiet;
    out_quiet = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(out_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int          pick;
    logic [31:0] fid;
    logic [31:0] blk;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    in_quiet = 0;
    file_pool[0] = 32'h0000_0000;
    file_pool[1] = $urandom;
    file_pool[2] = $urandom;
    file_pool[3] = 32'hFFFF_FFFF;
    foreach (block_pool[i]) block_pool[i] = $urandom;
    block_pool[0] = 32'h0000_0000;
    block_pool[1] = 32'hFFFF_FFFF;
    block_pool[2] = 32'h0000_0001;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send(make_item(MODE_READ, 32'h0, 32'h0));                  // miss into free entry
    send(make_item(MODE_READ, 32'h0, 32'h0));                  // read hit
    send(make_item(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // write hit
    send(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(MODE_CLOSE, 32'h5A5A_A5A5, 32'hFFFF_FFFF)); // close, nothing cached
    for (int i = 0; i < NUM_ENTRIES - 2; i++)
      send(make_item(MODE_WRITE, 32'hC0DE_0001, 32'(i)));
    // full cache, every bit set: sweep clears all and evicts entry 0
    send(make_item(MODE_READ, 32'hC0DE_0001, 32'h8000_0000));
    send(make_item(MODE_READ, 32'hC0DE_0001, 32'h0000_0100));
    // every entry belongs to this file now: longest flush
    send(make_item(MODE_CLOSE, 32'hC0DE_0001, 32'h0));
    send(make_item(MODE_READ, 32'h0, 32'h0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      fid  = file_pool[$urandom_range(0, 3)];
      blk  = block_pool[$urandom_range(0, 11)];
      if (pick < 40)      send(make_item(MODE_READ, fid, blk));
      else if (pick < 75) send(make_item(MODE_WRITE, fid, blk));
      else if (pick < 83) send(make_item(MODE_CLOSE, fid, $urandom));
      else if (pick < 88) send(make_item(MODE_CLOSE, $urandom, $urandom));
      else if (pick < 93) send(make_item(MODE_UNUSED, $urandom, $urandom));
      else send(make_item($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, $urandom, $urandom));
    end
    in_valid <= 1'b0;

    // let the checker see the last transaction before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results", n_in, n_out);
    $display("Hits %0d, evictions %0d, flushed entries %0d", n_hit, n_evict, n_flush);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
